// ===== rtl/rpvc_pkg.sv =====
// ----------------------------------------------------------------------------
// rpvc_pkg
// Shared types, register codes and the neighbor offset table of the regional
// peak and valley counter.
// ----------------------------------------------------------------------------
package rpvc_pkg;

  localparam int HEIGHT_W = 16;
  localparam int COUNT_W  = 13;
  localparam int CFG_W    = 7;
  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;

  // register index, taken from paddr[2]
  localparam logic REG_GRID_SIZE = 1'b0;

  localparam logic [CFG_W-1:0]   GRID_SIZE_RESET = 7'd64;
  localparam logic [COUNT_W-1:0] COUNT_MAX       = '1;

  // eight neighbors, then a drain step
  localparam logic [3:0] NBR_LAST = 4'd8;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_POP,
    ST_POP_WAIT,
    ST_NBR,
    ST_REGION_END,
    ST_DONE
  } rpvc_state_t;

  typedef struct packed {
    logic [COUNT_W-1:0] peak_count;
    logic [COUNT_W-1:0] valley_count;
  } rpvc_counts_t;

  // row step of neighbor k
  function automatic logic signed [1:0] nbr_dr(input logic [3:0] k);
    logic signed [1:0] d;
    case (k)
      4'd0, 4'd1, 4'd2: d = -2'sd1;
      4'd3, 4'd4:       d = 2'sd0;
      4'd5, 4'd6, 4'd7: d = 2'sd1;
      default:          d = 2'sd0;
    endcase
    return d;
  endfunction

  // column step of neighbor k
  function automatic logic signed [1:0] nbr_dc(input logic [3:0] k);
    logic signed [1:0] d;
    case (k)
      4'd0, 4'd3, 4'd5: d = -2'sd1;
      4'd1, 4'd6:       d = 2'sd0;
      4'd2, 4'd4, 4'd7: d = 2'sd1;
      default:          d = 2'sd0;
    endcase
    return d;
  endfunction

endpackage

// ===== rtl/rpvc_if.sv =====
// ----------------------------------------------------------------------------
// rpvc_if
// Valid/ready channels of the regional peak and valley counter: height
// samples in, peak and valley counts out.
// ----------------------------------------------------------------------------
interface rpvc_sample_if
  import rpvc_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [HEIGHT_W-1:0] height;

  modport source (output valid, output height, input ready);
  modport sink   (input valid, input height, output ready);
endinterface

interface rpvc_counts_if
  import rpvc_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] peak_count;
  logic [COUNT_W-1:0] valley_count;

  modport source (output valid, output peak_count, output valley_count, input ready);
  modport sink   (input valid, input peak_count, input valley_count, output ready);
endinterface

// ===== rtl/rpvc_ram.sv =====
// ----------------------------------------------------------------------------
// rpvc_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module rpvc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/rpvc_core.sv =====
// ----------------------------------------------------------------------------
// rpvc_core
// Map loader and flood-fill sequencer. Stores the heights, then scans the
// cells and fills each unvisited equal-height region through a stack in RAM,
// checking one neighbor per cycle through the shared memory read ports.
// ----------------------------------------------------------------------------
module rpvc_core
  import rpvc_pkg::*;
#(
  parameter int GRID_MAX    = 64,
  parameter int HEIGHT_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  rpvc_sample_if.sink                           samples,
  input  logic [$clog2(GRID_MAX+1)-1:0]         side,
  input  logic [$clog2(GRID_MAX*GRID_MAX)-1:0]  last_idx,
  input  logic                                  restart,
  output logic                                  res_valid,
  output rpvc_counts_t                          res,
  input  logic                                  res_take
);

  localparam int CELLS     = GRID_MAX * GRID_MAX;
  localparam int CELL_BITS = $clog2(CELLS);
  localparam int SW        = $clog2(GRID_MAX + 1);
  localparam int RC_BITS   = $clog2(GRID_MAX);
  localparam int STK_W     = 2 * RC_BITS;
  localparam int TOP_BITS  = CELL_BITS + 1;

  rpvc_state_t state, state_next;

  logic [CELL_BITS-1:0]   load_idx, load_idx_next;
  logic [CELL_BITS-1:0]   scan_idx, scan_idx_next;
  logic [RC_BITS-1:0]     scan_row, scan_row_next, scan_col, scan_col_next;
  logic [CELL_BITS-1:0]   cur_idx, cur_idx_next;
  logic [RC_BITS-1:0]     cur_row, cur_row_next, cur_col, cur_col_next;
  logic [HEIGHT_BITS-1:0] here, here_next;
  logic [3:0]             nbr_k, nbr_k_next;
  logic [TOP_BITS-1:0]    top, top_next;
  logic                   p_valid, p_valid_next;
  logic [CELL_BITS-1:0]   p_addr, p_addr_next;
  logic [RC_BITS-1:0]     p_row, p_row_next, p_col, p_col_next;
  logic                   saw_higher, saw_higher_next, saw_lower, saw_lower_next;
  logic [COUNT_W-1:0]     peaks, peaks_next, valleys, valleys_next;

  // memory ports
  logic                   h_we, v_we, s_we;
  logic [CELL_BITS-1:0]   h_waddr, h_raddr, v_waddr, v_raddr, s_waddr, s_raddr;
  logic [HEIGHT_BITS-1:0] h_wdata, h_rdata;
  logic                   v_wdata, v_rdata;
  logic [STK_W-1:0]       s_wdata, s_rdata;

  logic [HEIGHT_W+31:0]   height_ext;
  logic [HEIGHT_BITS-1:0] height_val;
  logic [RC_BITS-1:0]     side_m1;
  logic [CELL_BITS-1:0]   side_c;
  logic                   scan_last;
  logic [RC_BITS+SW-1:0]  row_mul;
  logic signed [1:0]      dr, dc;
  logic [CELL_BITS-1:0]   nb_addr;
  logic [RC_BITS-1:0]     nb_row, nb_col;
  logic                   nb_ok;
  logic [RC_BITS-1:0]     pop_row, pop_col;

  assign height_ext = {32'd0, samples.height};
  assign height_val = height_ext[HEIGHT_BITS-1:0];
  assign side_m1    = RC_BITS'(side - SW'(1));
  assign side_c     = CELL_BITS'(side);
  assign scan_last  = (scan_idx == last_idx);

  assign pop_row = s_rdata[STK_W-1:RC_BITS];
  assign pop_col = s_rdata[RC_BITS-1:0];
  assign row_mul = RC_BITS'(pop_row) * side;

  // neighbor address and bounds of step nbr_k around the current cell
  always_comb begin
    dr      = nbr_dr(nbr_k);
    dc      = nbr_dc(nbr_k);
    nb_addr = cur_idx;
    nb_row  = cur_row;
    nb_col  = cur_col;
    nb_ok   = (nbr_k != NBR_LAST);
    if (dr < 0) begin
      nb_addr = nb_addr - side_c;
      nb_row  = cur_row - RC_BITS'(1);
      if (cur_row == '0) nb_ok = 1'b0;
    end else if (dr > 0) begin
      nb_addr = nb_addr + side_c;
      nb_row  = cur_row + RC_BITS'(1);
      if (cur_row == side_m1) nb_ok = 1'b0;
    end
    if (dc < 0) begin
      nb_addr = nb_addr - CELL_BITS'(1);
      nb_col  = cur_col - RC_BITS'(1);
      if (cur_col == '0) nb_ok = 1'b0;
    end else if (dc > 0) begin
      nb_addr = nb_addr + CELL_BITS'(1);
      nb_col  = cur_col + RC_BITS'(1);
      if (cur_col == side_m1) nb_ok = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next      = state;
    load_idx_next   = load_idx;
    scan_idx_next   = scan_idx;
    scan_row_next   = scan_row;
    scan_col_next   = scan_col;
    cur_idx_next    = cur_idx;
    cur_row_next    = cur_row;
    cur_col_next    = cur_col;
    here_next       = here;
    nbr_k_next      = nbr_k;
    top_next        = top;
    p_valid_next    = 1'b0;
    p_addr_next     = p_addr;
    p_row_next      = p_row;
    p_col_next      = p_col;
    saw_higher_next = saw_higher;
    saw_lower_next  = saw_lower;
    peaks_next      = peaks;
    valleys_next    = valleys;

    h_we    = 1'b0;
    h_waddr = load_idx;
    h_wdata = height_val;
    h_raddr = nb_addr;
    v_we    = 1'b0;
    v_waddr = load_idx;
    v_wdata = 1'b0;
    v_raddr = nb_addr;
    s_we    = 1'b0;
    s_waddr = top[CELL_BITS-1:0];
    s_wdata = {p_row, p_col};
    s_raddr = CELL_BITS'(top - TOP_BITS'(1));

    samples.ready = 1'b0;
    res_valid     = 1'b0;

    case (state)
      ST_LOAD: begin
        samples.ready = 1'b1;
        if (samples.valid) begin
          // clear the visited bit of each cell as its height arrives
          h_we = 1'b1;
          v_we = 1'b1;
          if (load_idx == last_idx) begin
            load_idx_next = '0;
            scan_idx_next = '0;
            scan_row_next = '0;
            scan_col_next = '0;
            peaks_next    = '0;
            valleys_next  = '0;
            state_next    = ST_SCAN_RD;
          end else begin
            load_idx_next = load_idx + CELL_BITS'(1);
          end
        end
        if (restart) begin
          load_idx_next = '0;
        end
      end

      ST_SCAN_RD: begin
        v_raddr    = scan_idx;
        state_next = ST_SCAN_CHK;
      end

      ST_SCAN_CHK: begin
        if (!v_rdata) begin
          // seed a new region
          v_we            = 1'b1;
          v_waddr         = scan_idx;
          v_wdata         = 1'b1;
          s_we            = 1'b1;
          s_waddr         = '0;
          s_wdata         = {scan_row, scan_col};
          top_next        = TOP_BITS'(1);
          saw_higher_next = 1'b0;
          saw_lower_next  = 1'b0;
          state_next      = ST_POP;
        end else if (scan_last) begin
          state_next = ST_DONE;
        end else begin
          scan_idx_next = scan_idx + CELL_BITS'(1);
          if (scan_col == side_m1) begin
            scan_col_next = '0;
            scan_row_next = scan_row + RC_BITS'(1);
          end else begin
            scan_col_next = scan_col + RC_BITS'(1);
          end
          state_next = ST_SCAN_RD;
        end
      end

      ST_POP: begin
        if (top == '0) begin
          state_next = ST_REGION_END;
        end else begin
          top_next   = top - TOP_BITS'(1);
          state_next = ST_POP_WAIT;
        end
      end

      ST_POP_WAIT: begin
        cur_row_next = pop_row;
        cur_col_next = pop_col;
        cur_idx_next = CELL_BITS'(row_mul + (RC_BITS + SW)'(pop_col));
        h_raddr      = cur_idx_next;
        nbr_k_next   = '0;
        state_next   = ST_NBR;
      end

      ST_NBR: begin
        if (nbr_k == '0) begin
          here_next = h_rdata;
        end
        // issue the read of neighbor k
        p_valid_next = nb_ok;
        p_addr_next  = nb_addr;
        p_row_next   = nb_row;
        p_col_next   = nb_col;
        // evaluate neighbor k-1
        if (p_valid) begin
          if (h_rdata > here) begin
            saw_higher_next = 1'b1;
          end else if (h_rdata < here) begin
            saw_lower_next = 1'b1;
          end else if (!v_rdata) begin
            v_we     = 1'b1;
            v_waddr  = p_addr;
            v_wdata  = 1'b1;
            s_we     = 1'b1;
            top_next = top + TOP_BITS'(1);
          end
        end
        if (nbr_k == NBR_LAST) begin
          state_next = ST_POP;
        end else begin
          nbr_k_next = nbr_k + 4'd1;
        end
      end

      ST_REGION_END: begin
        if (!(saw_higher && saw_lower)) begin
          if (saw_higher && valleys != COUNT_MAX) valleys_next = valleys + COUNT_W'(1);
          if (saw_lower && peaks != COUNT_MAX)    peaks_next   = peaks + COUNT_W'(1);
        end
        if (scan_last) begin
          state_next = ST_DONE;
        end else begin
          scan_idx_next = scan_idx + CELL_BITS'(1);
          if (scan_col == side_m1) begin
            scan_col_next = '0;
            scan_row_next = scan_row + RC_BITS'(1);
          end else begin
            scan_col_next = scan_col + RC_BITS'(1);
          end
          state_next = ST_SCAN_RD;
        end
      end

      ST_DONE: begin
        res_valid = 1'b1;
        if (res_take) begin
          state_next = ST_LOAD;
        end
      end

      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  // a flat map reports one of each
  always_comb begin
    if (peaks == '0 && valleys == '0) begin
      res.peak_count   = COUNT_W'(1);
      res.valley_count = COUNT_W'(1);
    end else begin
      res.peak_count   = peaks;
      res.valley_count = valleys;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_idx   <= '0;
      top        <= '0;
      p_valid    <= 1'b0;
      saw_higher <= 1'b0;
      saw_lower  <= 1'b0;
      peaks      <= '0;
      valleys    <= '0;
      nbr_k      <= '0;
    end else begin
      load_idx   <= load_idx_next;
      top        <= top_next;
      p_valid    <= p_valid_next;
      saw_higher <= saw_higher_next;
      saw_lower  <= saw_lower_next;
      peaks      <= peaks_next;
      valleys    <= valleys_next;
      nbr_k      <= nbr_k_next;
    end
  end

  always_ff @(posedge clk) begin
    scan_idx <= scan_idx_next;
    scan_row <= scan_row_next;
    scan_col <= scan_col_next;
    cur_idx  <= cur_idx_next;
    cur_row  <= cur_row_next;
    cur_col  <= cur_col_next;
    here     <= here_next;
    p_addr   <= p_addr_next;
    p_row    <= p_row_next;
    p_col    <= p_col_next;
  end

  rpvc_ram #(.WIDTH(HEIGHT_BITS), .DEPTH(CELLS)) u_height (
    .clk   (clk),
    .we    (h_we),
    .waddr (h_waddr),
    .wdata (h_wdata),
    .raddr (h_raddr),
    .rdata (h_rdata)
  );

  rpvc_ram #(.WIDTH(1), .DEPTH(CELLS)) u_visited (
    .clk   (clk),
    .we    (v_we),
    .waddr (v_waddr),
    .wdata (v_wdata),
    .raddr (v_raddr),
    .rdata (v_rdata)
  );

  rpvc_ram #(.WIDTH(STK_W), .DEPTH(CELLS)) u_stack (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

endmodule

// ===== rtl/regional_peak_valley_counter.sv =====
// ----------------------------------------------------------------------------
// regional_peak_valley_counter
// Counts 8-connected equal-height regions of a square height map that are
// peaks (only lower neighbors) or valleys (only higher neighbors).
// ----------------------------------------------------------------------------
// Usage:
//   samples: one height per transaction, row-major, clamped grid_size squared
//   per map. The channel is ready only while a map is loading, one sample/cycle.
//   counts: one transaction per map, peak_count and valley_count; a flat
//   map reports 1 and 1.
//   APB register 0 (byte address 0): grid_size, reset 64. A write restarts
//   the map being loaded; write only while the block is idle.
// Fill: after the last sample each scanned cell has its visited bit read
//   and checked. Each cell popped from the region stack takes a pop, a pop
//   wait, eight neighbor reads through the height and visited RAM read
//   ports (one per cycle) and a drain step; each region ends in a count
//   update, then result hand-off; each RAM's single read port sets the pace.
// Reset: back to loading, partial map dropped, no result pending.
// Stall: the result sits in an output register; loading of the next map
//   goes on, and only its own hand-off waits until that register is free.
// ----------------------------------------------------------------------------
module regional_peak_valley_counter
  import rpvc_pkg::*;
#(
  parameter int GRID_MAX    = 64,
  parameter int HEIGHT_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  rpvc_sample_if.sink       samples,
  rpvc_counts_if.source     counts
);

  localparam int CELL_BITS  = $clog2(GRID_MAX * GRID_MAX);
  localparam int SW         = $clog2(GRID_MAX + 1);
  localparam int SIDE_RESET = (64 > GRID_MAX) ? GRID_MAX : 64;
  localparam int LAST_RESET = SIDE_RESET * SIDE_RESET - 1;

  logic [CFG_W-1:0]     grid_size;
  logic [SW-1:0]        side, side_next;
  logic [CELL_BITS-1:0] last_idx, last_idx_next;
  logic [2*SW-1:0]      side_sq;
  logic [CFG_W-1:0]     wr_size;
  logic                 cfg_wr;

  logic                 res_valid, res_take;
  rpvc_counts_t         res;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && (paddr[2] == REG_GRID_SIZE);
  assign wr_size = pwdata[CFG_W-1:0];
  assign prdata  = (paddr[2] == REG_GRID_SIZE) ? DATA_W'(grid_size) : '0;

  // clamp the side to 1..GRID_MAX
  always_comb begin
    if (wr_size == '0) begin
      side_next = SW'(1);
    end else if (32'(wr_size) > GRID_MAX) begin
      side_next = SW'(GRID_MAX);
    end else begin
      side_next = SW'(wr_size);
    end
    side_sq       = side_next * side_next;
    last_idx_next = CELL_BITS'(side_sq - (2 * SW)'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_size <= GRID_SIZE_RESET;
      side      <= SW'(SIDE_RESET);
      last_idx  <= CELL_BITS'(LAST_RESET);
    end else if (cfg_wr) begin
      grid_size <= wr_size;
      side      <= side_next;
      last_idx  <= last_idx_next;
    end
  end

  rpvc_core #(
    .GRID_MAX    (GRID_MAX),
    .HEIGHT_BITS (HEIGHT_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .samples   (samples),
    .side      (side),
    .last_idx  (last_idx),
    .restart   (cfg_wr),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take)
  );

  // output register
  assign res_take = !counts.valid || counts.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      counts.valid <= 1'b0;
    end else if (res_valid && res_take) begin
      counts.valid <= 1'b1;
    end else if (counts.ready) begin
      counts.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_take) begin
      counts.peak_count   <= res.peak_count;
      counts.valley_count <= res.valley_count;
    end
  end

  a_no_out_after_reset: assert property (@(posedge clk)
    rst |=> !counts.valid)
    else $error("result valid right after reset");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_take |=> res_valid)
    else $error("finished result dropped while output register busy");

  a_counts_nonzero: assert property (@(posedge clk) disable iff (rst)
    counts.valid |-> (counts.peak_count != '0 || counts.valley_count != '0))
    else $error("result with both counts zero");

  a_no_load_while_result: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !samples.ready)
    else $error("samples accepted while a result waits for hand-off");

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for regional_peak_valley_counter. Height maps stream in
// over the sample channel with random gaps, and a local flood-fill predictor
// works out the peak and valley counts of each completed map. Each counts
// transaction is checked against the oldest prediction. grid_size is
// programmed over APB between maps.
// ----------------------------------------------------------------------------
module tb_top;
  import rpvc_pkg::*;

  localparam int          GRID_MAX      = 64;
  localparam int          CELLS_MAX     = GRID_MAX * GRID_MAX;
  localparam int          RANDOM_ITEMS  = 450;
  localparam int          LARGE_PARTIAL = 300;
  localparam int          SETTLE_PAUSE  = 16;
  localparam int          END_PAUSE     = 64;
  localparam int          STALL_CYCLES  = 2000;
  localparam int          MAX_PRINTS    = 50;
  localparam int unsigned CYCLE_LIMIT   = 2_000_000;

  localparam logic [ADDR_W-1:0] GRID_SIZE_ADDR = ADDR_W'({REG_GRID_SIZE, 2'b00});

  typedef enum int {
    PAT_FLAT,
    PAT_STEPS,
    PAT_NOISE,
    PAT_EXTREME,
    PAT_RAMP
  } map_pattern_t;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  rpvc_sample_if sample_ch ();
  rpvc_counts_if count_ch ();

  regional_peak_valley_counter #(
    .GRID_MAX   (GRID_MAX),
    .HEIGHT_BITS(HEIGHT_W)
  ) uut (
    .clk    (clk),
    .rst    (rst),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .samples(sample_ch),
    .counts (count_ch)
  );

  // predictor state
  logic [CFG_W-1:0]    grid_reg;
  int unsigned         load_pos;
  logic [HEIGHT_W-1:0] map_height [CELLS_MAX];
  bit                  region_seen [CELLS_MAX];
  int unsigned         cell_stack [CELLS_MAX];
  rpvc_counts_t        expected_counts [$];

  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_left   = 0;
  int unsigned rx_gap      = 0;
  bit          counts_taken = 1'b0;
  bit          idle_on      = 1'b1;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= MAX_PRINTS) $display("ERROR @%0t: %s", $time, msg);
  endtask

  function automatic int unsigned draw_gap();
    return idle_on ? $urandom_range(0, 17) : 0;
  endfunction

  function automatic int unsigned side_of(input logic [CFG_W-1:0] raw);
    if (raw == 0) return 1;
    if (raw > GRID_MAX) return GRID_MAX;
    return 32'(raw);
  endfunction

  // Flood-fill every equal-height region of the stored map and classify it.
  function automatic rpvc_counts_t count_regions(input int unsigned side);
    int unsigned  cells, top, cur, row, col, nb, peaks, valleys;
    int           r, c;
    logic [HEIGHT_W-1:0] here, there;
    bit           higher, lower;
    rpvc_counts_t res;
    cells   = side * side;
    peaks   = 0;
    valleys = 0;
    for (int unsigned i = 0; i < CELLS_MAX; i++) region_seen[i] = 1'b0;
    for (int unsigned i = 0; i < cells; i++) begin
      if (region_seen[i]) continue;
      higher         = 1'b0;
      lower          = 1'b0;
      region_seen[i] = 1'b1;
      cell_stack[0]  = i;
      top            = 1;
      while (top > 0) begin
        top  = top - 1;
        cur  = cell_stack[top];
        row  = cur / side;
        col  = cur % side;
        here = map_height[cur];
        for (int dr = -1; dr <= 1; dr++) begin
          for (int dc = -1; dc <= 1; dc++) begin
            r = int'(row) + dr;
            c = int'(col) + dc;
            if (r < 0 || c < 0 || r >= int'(side) || c >= int'(side)) continue;
            nb    = r * side + c;
            there = map_height[nb];
            if (there > here) begin
              higher = 1'b1;
            end else if (there < here) begin
              lower = 1'b1;
            end else if (!region_seen[nb] && top < CELLS_MAX) begin
              region_seen[nb] = 1'b1;
              cell_stack[top] = nb;
              top             = top + 1;
            end
          end
        end
      end
      if (higher && lower) continue;
      if (higher && valleys < COUNT_MAX) valleys++;
      if (lower && peaks < COUNT_MAX) peaks++;
    end
    // a flat map reports one of each
    if (peaks == 0 && valleys == 0) begin
      peaks   = 1;
      valleys = 1;
    end
    res.peak_count   = COUNT_W'(peaks);
    res.valley_count = COUNT_W'(valleys);
    return res;
  endfunction

  function automatic void load_height(input logic [HEIGHT_W-1:0] h);
    int unsigned cells;
    cells = side_of(grid_reg) * side_of(grid_reg);
    if (load_pos >= cells) load_pos = 0;
    map_height[load_pos] = h;
    load_pos++;
    if (load_pos == cells) begin
      load_pos = 0;
      expected_counts.push_back(count_regions(side_of(grid_reg)));
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && sample_ch.valid && sample_ch.ready) load_height(sample_ch.height);
  end

  always @(posedge clk) begin : check_counts
    rpvc_counts_t want;
    if (!rst && count_ch.valid && count_ch.ready) begin
      counts_taken = 1'b1;
      if (expected_counts.size() == 0) begin
        report_mismatch($sformatf("unexpected counts transaction peak=%0d valley=%0d",
                                  count_ch.peak_count, count_ch.valley_count));
      end else begin
        want = expected_counts.pop_front();
        if (count_ch.peak_count !== want.peak_count)
          report_mismatch($sformatf("peak_count got %0d want %0d",
                                    count_ch.peak_count, want.peak_count));
        if (count_ch.valley_count !== want.valley_count)
          report_mismatch($sformatf("valley_count got %0d want %0d",
                                    count_ch.valley_count, want.valley_count));
      end
    end
  end

  // long receiver hold-off, counted down here
  always @(posedge clk) begin
    if (hold_left != 0) hold_left <= hold_left - 1;
  end

  // counts receiver: draw a fresh wait after every transaction
  always @(negedge clk) begin
    if (rst) begin
      count_ch.ready <= 1'b0;
    end else begin
      if (counts_taken) begin
        rx_gap       = draw_gap();
        counts_taken = 1'b0;
      end
      if (hold_left != 0 || rx_gap != 0) begin
        count_ch.ready <= 1'b0;
        if (rx_gap != 0) rx_gap = rx_gap - 1;
      end else begin
        count_ch.ready <= 1'b1;
      end
    end
  end

  // valid stays high after a transaction so back-to-back samples need no gap
  task automatic send_height(input logic [HEIGHT_W-1:0] h);
    int unsigned gap;
    gap = draw_gap();
    repeat (gap) begin
      @(negedge clk);
      sample_ch.valid <= 1'b0;
    end
    @(negedge clk);
    sample_ch.valid  <= 1'b1;
    sample_ch.height <= h;
    do @(posedge clk); while (!sample_ch.ready);
  endtask

  function automatic logic [HEIGHT_W-1:0] draw_height(input map_pattern_t pattern,
                                                     input logic [HEIGHT_W-1:0] base,
                                                     input int unsigned row,
                                                     input int unsigned col);
    case (pattern)
      PAT_FLAT:    return base;
      PAT_STEPS:   return base + HEIGHT_W'($urandom_range(0, 2));
      PAT_NOISE:   return HEIGHT_W'($urandom);
      PAT_EXTREME: return $urandom_range(0, 1) ? '1 : '0;
      default:     return HEIGHT_W'((row + col) * 1000);
    endcase
  endfunction

  function automatic map_pattern_t pick_pattern();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return PAT_STEPS;
    if (roll < 70) return PAT_NOISE;
    if (roll < 85) return PAT_EXTREME;
    if (roll < 90) return PAT_FLAT;
    return PAT_RAMP;
  endfunction

  task automatic send_map(input int unsigned side, input map_pattern_t pattern);
    logic [HEIGHT_W-1:0] base;
    base = HEIGHT_W'($urandom_range(0, 65533));
    for (int unsigned idx = 0; idx < side * side; idx++)
      send_height(draw_height(pattern, base, idx / side, idx % side));
  endtask

  // drop valid, let every pending result arrive, then pause
  task automatic settle_block(input int pause);
    @(negedge clk);
    sample_ch.valid <= 1'b0;
    while (expected_counts.size() != 0) @(posedge clk);
    repeat (pause) @(posedge clk);
  endtask

  task automatic apb_xfer(input bit is_write, input logic [DATA_W-1:0] wdata,
                          output logic [DATA_W-1:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= GRID_SIZE_ADDR;
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    if (is_write) begin
      grid_reg = wdata[CFG_W-1:0];
      load_pos = 0;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_grid_reg();
    logic [DATA_W-1:0] rdata;
    apb_xfer(1'b0, '0, rdata);
    if (rdata[CFG_W-1:0] !== grid_reg)
      report_mismatch($sformatf("grid_size read %0d want %0d", rdata[CFG_W-1:0], grid_reg));
  endtask

  task automatic set_grid_size(input logic [CFG_W-1:0] size, input bit scramble);
    logic [DATA_W-1:0] wdata, rdata;
    wdata            = scramble ? DATA_W'($urandom) : '0;
    wdata[CFG_W-1:0] = size;
    settle_block(SETTLE_PAUSE);
    apb_xfer(1'b1, wdata, rdata);
    check_grid_reg();
  endtask

  task automatic test_reset_size();
    check_grid_reg();
  endtask

  task automatic test_single_cell();
    set_grid_size(CFG_W'(1), 1'b0);
    send_height('0);
    send_height('1);
    send_height(16'h5555);
    send_height(16'hAAAA);
    // zero acts as a side of one
    set_grid_size('0, 1'b1);
    send_height(HEIGHT_W'($urandom));
    send_height(HEIGHT_W'($urandom));
  endtask

  task automatic test_two_by_two();
    logic [HEIGHT_W-1:0] cells [16];
    cells = '{16'hFFFF, 16'h0000, 16'h0000, 16'h0000,
              16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF,
              16'h0007, 16'h0007, 16'h0007, 16'h0007,
              16'h0001, 16'h0002, 16'h0002, 16'h0001};
    set_grid_size(CFG_W'(2), 1'b0);
    foreach (cells[i]) send_height(cells[i]);
  endtask

  task automatic test_mid_map_write();
    set_grid_size(CFG_W'(3), 1'b1);
    repeat (5) send_height(HEIGHT_W'($urandom));
    // the partial map above must be dropped
    set_grid_size(CFG_W'(2), 1'b0);
    send_map(2, PAT_STEPS);
  endtask

  task automatic test_output_stall();
    set_grid_size(CFG_W'(2), 1'b0);
    idle_on = 1'b0;
    @(posedge clk);
    hold_left <= STALL_CYCLES;
    repeat (12) send_map(2, PAT_STEPS);
    idle_on = 1'b1;
  endtask

  task automatic test_random_maps();
    int unsigned      sent, roll, side, partial;
    logic [CFG_W-1:0] size;
    bit               must_write;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      roll = $urandom_range(0, 99);
      if (roll < 70) size = CFG_W'($urandom_range(1, 6));
      else if (roll < 95) size = CFG_W'($urandom_range(7, 12));
      else size = CFG_W'($urandom_range(13, 20));
      if ($urandom_range(0, 19) == 0) size = '0;
      must_write = (size != grid_reg) || ($urandom_range(0, 3) == 0);
      // broken map: stop short and resize
      if ($urandom_range(0, 9) == 0) begin
        side    = side_of(grid_reg);
        partial = $urandom_range(0, side * side - 1);
        repeat (partial) send_height(HEIGHT_W'($urandom));
        must_write = 1'b1;
      end
      if (must_write) set_grid_size(size, 1'($urandom_range(0, 1)));
      idle_on = ($urandom_range(0, 4) != 0);
      side    = side_of(size);
      send_map(side, pick_pattern());
      sent += side * side;
    end
    idle_on = 1'b1;
  endtask

  task automatic test_largest_grid();
    // above the range: acts as the largest side, so this partial map never
    // completes and is dropped by the resize
    set_grid_size('1, 1'b1);
    repeat (LARGE_PARTIAL) send_height(HEIGHT_W'($urandom));
    set_grid_size(CFG_W'(20), 1'b0);
    idle_on = 1'b0;
    send_map(20, PAT_STEPS);
    idle_on = 1'b1;
  endtask

  initial begin
    rst              = 1'b1;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    sample_ch.valid  = 1'b0;
    sample_ch.height = '0;
    count_ch.ready   = 1'b0;
    grid_reg         = GRID_SIZE_RESET;
    load_pos         = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_size();
    test_single_cell();
    test_two_by_two();
    test_mid_map_write();
    test_output_stall();
    test_random_maps();
    test_largest_grid();
    settle_block(END_PAUSE);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/rpvc_pkg.sv
rtl/rpvc_if.sv
rtl/rpvc_ram.sv
rtl/rpvc_core.sv
rtl/regional_peak_valley_counter.sv
bench/tb_top.sv
